// File: rtl/mqm_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Mailbox package
// Sizes, codes and shared types of the multi-queue mailbox.
// ----------------------------------------------------------------------------
package mqm_pkg;

	function automatic int clog2_min1(input int v);
		return (v > 1) ? $clog2(v) : 1;
	endfunction

	// Configuration
	localparam int NUM_SLOTS      = 8;
	localparam int SLOT_DEPTH     = 8;
	localparam int MAX_MSG_BYTES  = 512;
	localparam int DEFAULT_LIMIT  = 128;
	localparam int BEAT_BYTES     = 8;
	localparam int WORDS_PER_MSG  = (MAX_MSG_BYTES + BEAT_BYTES - 1) / BEAT_BYTES;
	localparam int LIMIT_RESET    = (DEFAULT_LIMIT < MAX_MSG_BYTES) ? DEFAULT_LIMIT
	                                                                : MAX_MSG_BYTES;

	// Field widths
	localparam int ACT_W  = 2;
	localparam int SLOT_W = 3;
	localparam int DATA_W = 64;
	localparam int BC_W   = 4;
	localparam int AMT_W  = 16;
	localparam int STAT_W = 3;
	localparam int LEN_W  = 10;

	// Derived widths
	localparam int SIDX_W   = clog2_min1(NUM_SLOTS);
	localparam int ENTRY_W  = clog2_min1(SLOT_DEPTH);
	localparam int CNT_W    = $clog2(SLOT_DEPTH + 1);
	localparam int WORD_W   = clog2_min1(WORDS_PER_MSG);
	localparam int WCNT_W   = $clog2(WORDS_PER_MSG + 1);
	localparam int LENS_AW  = clog2_min1(NUM_SLOTS * SLOT_DEPTH);
	localparam int STORE_AW = clog2_min1(NUM_SLOTS * SLOT_DEPTH * WORDS_PER_MSG);

	typedef enum logic [ACT_W-1:0] {
		ACT_WRITE = 2'd0,
		ACT_READ  = 2'd1,
		ACT_LIMIT = 2'd2,
		ACT_OTHER = 2'd3
	} action_t;

	typedef enum logic [STAT_W-1:0] {
		ST_OK      = 3'd0,
		ST_EMPTY   = 3'd1,
		ST_FULL    = 3'd2,
		ST_BIG     = 3'd3,
		ST_SMALL   = 3'd4,
		ST_INVALID = 3'd5,
		ST_UNKNOWN = 3'd6
	} status_t;

	typedef enum logic [1:0] {
		FS_IDLE,
		FS_FLUSH,
		FS_RD_LEN,
		FS_RD_DATA
	} fsm_state_t;

	typedef struct packed {
		logic [SLOT_W-1:0] slot;
		logic [DATA_W-1:0] data;
		logic [BC_W-1:0]   byte_count;
		logic              last;
	} wbeat_t;

	typedef struct packed {
		status_t          status;
		logic [LEN_W-1:0] length;
		logic             push;
		logic             flush;
	} wres_t;

	typedef struct packed {
		logic             push;
		logic             pop;
		logic             set_lim;
		logic [LEN_W-1:0] lim;
	} meta_upd_t;

	typedef struct packed {
		logic [ENTRY_W-1:0] head;
		logic [CNT_W-1:0]   count;
		logic [LEN_W-1:0]   limit;
		logic [ENTRY_W-1:0] tail;
	} meta_view_t;

	typedef struct packed {
		logic                we;
		logic [STORE_AW-1:0] addr;
		logic [DATA_W-1:0]   data;
	} store_wr_t;

	typedef struct packed {
		logic               we;
		logic [LENS_AW-1:0] addr;
		logic [LEN_W-1:0]   data;
	} lens_wr_t;

	function automatic logic slot_ok(input logic [SLOT_W-1:0] s);
		return int'(s) < NUM_SLOTS;
	endfunction

	function automatic logic [SIDX_W-1:0] slot_idx(input logic [SLOT_W-1:0] s);
		return SIDX_W'(s);
	endfunction

	function automatic logic [LENS_AW-1:0] lens_addr(input logic [SIDX_W-1:0] s,
	                                                 input logic [ENTRY_W-1:0] e);
		return LENS_AW'(int'(s) * SLOT_DEPTH + int'(e));
	endfunction

	function automatic logic [STORE_AW-1:0] store_addr(input logic [SIDX_W-1:0] s,
	                                                   input logic [ENTRY_W-1:0] e,
	                                                   input logic [WORD_W-1:0] w);
		return STORE_AW'((int'(s) * SLOT_DEPTH + int'(e)) * WORDS_PER_MSG + int'(w));
	endfunction

endpackage
`default_nettype wire

// File: rtl/mqm_in_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Mailbox command channel
// Valid/ready channel carrying one command item.
// ----------------------------------------------------------------------------
interface mqm_in_if import mqm_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [ACT_W-1:0]  action;
	logic [SLOT_W-1:0] slot;
	logic [DATA_W-1:0] data;
	logic [BC_W-1:0]   byte_count;
	logic              last;
	logic [AMT_W-1:0]  amount;

	modport source (output valid, action, slot, data, byte_count, last, amount,
	                input ready);
	modport sink   (input valid, action, slot, data, byte_count, last, amount,
	                output ready);
endinterface
`default_nettype wire

// File: rtl/mqm_out_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Mailbox result channel
// Valid/ready channel carrying one result item.
// ----------------------------------------------------------------------------
interface mqm_out_if import mqm_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [STAT_W-1:0] status;
	logic [DATA_W-1:0] data_res;
	logic [BC_W-1:0]   byte_count_res;
	logic [LEN_W-1:0]  length;
	logic              last_res;

	modport source (output valid, status, data_res, byte_count_res, length, last_res,
	                input ready);
	modport sink   (input valid, status, data_res, byte_count_res, length, last_res,
	                output ready);
endinterface
`default_nettype wire

// File: rtl/multi_queue_mailbox.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Multi-queue mailbox
// Several message FIFOs in one word store, written in beats, read in bursts.
// ----------------------------------------------------------------------------
//
//  Channel  Side    Handshake    Item contents
//  -------  ------  -----------  ----------------------------------------------
//  cmd      sink    valid/ready  action, slot, data, byte_count, last, amount
//  res      source  valid/ready  status, data_res, byte_count_res, length,
//                                last_res
//
//  A final write beat whose bytes straddle two store words is followed by a
//  flush state that writes the second word (single store write port). A read
//  first looks up the length memory, then fetches ceil(length/8) store words,
//  one per result beat; an invalid or empty read is answered from idle, a read
//  whose buffer is too small is answered after the length lookup.
//  Reset: the bookkeeping flops clear at once; the store and the length memory
//  need no clearing pass, as only written entries are ever read.
//  Stalls: one output register sits in front of res; cmd is taken in idle
//  whenever that register is empty or drains in the same cycle.
// ----------------------------------------------------------------------------
module multi_queue_mailbox import mqm_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	mqm_in_if.sink    cmd,
	mqm_out_if.source res
);
	fsm_state_t state_q, state_d;

	// Read context
	logic [SIDX_W-1:0]  rd_slot_q;
	logic [ENTRY_W-1:0] rd_head_q;
	logic [AMT_W-1:0]   rd_amt_q;
	logic [LEN_W-1:0]   rd_len_q;
	logic [WCNT_W-1:0]  nb_q;
	logic [WCNT_W-1:0]  issue_k_q;
	logic [WORD_W-1:0]  pend_k_q;
	logic               pend_valid_q;

	// Output register
	logic               res_valid_q;
	status_t            res_status_q;
	logic [DATA_W-1:0]  res_data_q;
	logic [BC_W-1:0]    res_bc_q;
	logic [LEN_W-1:0]   res_len_q;
	logic               res_last_q;

	logic               can_load;
	logic               cmd_acc;
	logic               load_en;
	status_t            load_status;
	logic [DATA_W-1:0]  load_data;
	logic [BC_W-1:0]    load_bc;
	logic [LEN_W-1:0]   load_len;
	logic               load_last;

	logic               beat_en;
	wbeat_t             beat;
	wres_t              wr_res;
	logic               wp_busy;
	logic [SLOT_W-1:0]  wp_slot;
	store_wr_t          st_wr;
	lens_wr_t           ln_wr;

	logic [SIDX_W-1:0]  meta_idx;
	meta_upd_t          upd;
	meta_view_t         view;

	logic               ln_re;
	logic [LEN_W-1:0]   ln_rdata;
	logic               st_re;
	logic [STORE_AW-1:0] st_raddr;
	logic [DATA_W-1:0]  st_rdata;
	logic [WORD_W-1:0]  st_k;

	logic               rd_latch;
	logic               len_latch;
	logic               issue;
	logic               consume;
	logic [LEN_W:0]     nb_sum;
	logic [WCNT_W-1:0]  nb_new;
	logic [LEN_W-1:0]   rem;
	logic [BC_W-1:0]    beat_bytes;
	logic [DATA_W-1:0]  beat_data;
	logic               beat_last;

	assign can_load  = !res_valid_q || res.ready;
	assign cmd.ready = (state_q == FS_IDLE) && can_load;
	assign cmd_acc   = cmd.valid && cmd.ready;

	assign beat.slot       = cmd.slot;
	assign beat.data       = cmd.data;
	assign beat.byte_count = cmd.byte_count;
	assign beat.last       = cmd.last;

	// One slot is looked at per cycle: the write slot for a running message,
	// the command slot otherwise, the read slot while a read is under way.
	always_comb begin
		if (state_q != FS_IDLE) begin
			meta_idx = rd_slot_q;
		end else if (action_t'(cmd.action) == ACT_WRITE && wp_busy) begin
			meta_idx = slot_idx(wp_slot);
		end else begin
			meta_idx = slot_idx(cmd.slot);
		end
	end

	mqm_meta u_meta (
		.clk    (clk),
		.arst_n (arst_n),
		.idx    (meta_idx),
		.upd    (upd),
		.view   (view)
	);

	mqm_wpack u_wpack (
		.clk     (clk),
		.arst_n  (arst_n),
		.beat_en (beat_en),
		.beat    (beat),
		.view    (view),
		.busy    (wp_busy),
		.slot_q  (wp_slot),
		.res     (wr_res),
		.st_wr   (st_wr),
		.ln_wr   (ln_wr)
	);

	mqm_ram #(
		.WIDTH  (DATA_W),
		.ADDR_W (STORE_AW)
	) u_store (
		.clk   (clk),
		.we    (st_wr.we),
		.waddr (st_wr.addr),
		.wdata (st_wr.data),
		.re    (st_re),
		.raddr (st_raddr),
		.rdata (st_rdata)
	);

	mqm_ram #(
		.WIDTH  (LEN_W),
		.ADDR_W (LENS_AW)
	) u_lens (
		.clk   (clk),
		.we    (ln_wr.we),
		.waddr (ln_wr.addr),
		.wdata (ln_wr.data),
		.re    (ln_re),
		.raddr (lens_addr(view.head == view.head ? slot_idx(cmd.slot) : rd_slot_q,
		                  view.head)),
		.rdata (ln_rdata)
	);

	// Beat count of the message just looked up, and the shape of the pending beat
	always_comb begin
		nb_sum     = {1'b0, ln_rdata} + (LEN_W+1)'(BEAT_BYTES - 1);
		nb_new     = WCNT_W'(nb_sum >> 3);
		rem        = rd_len_q - LEN_W'({pend_k_q, 3'b000});
		beat_bytes = (rem >= LEN_W'(BEAT_BYTES)) ? BC_W'(BEAT_BYTES) : BC_W'(rem);
		for (int j = 0; j < BEAT_BYTES; j++) begin
			beat_data[8*j +: 8] = (j < int'(beat_bytes)) ? st_rdata[8*j +: 8] : 8'h00;
		end
		beat_last  = (WCNT_W'(pend_k_q) + WCNT_W'(1)) == nb_q;
		st_k       = (state_q == FS_RD_LEN) ? '0 : WORD_W'(issue_k_q);
		st_raddr   = store_addr(rd_slot_q, rd_head_q, st_k);
	end

	// Sequencer
	always_comb begin
		state_d     = state_q;
		load_en     = 1'b0;
		load_status = ST_OK;
		load_data   = '0;
		load_bc     = '0;
		load_len    = '0;
		load_last   = 1'b1;
		beat_en     = 1'b0;
		upd         = '0;
		ln_re       = 1'b0;
		st_re       = 1'b0;
		rd_latch    = 1'b0;
		len_latch   = 1'b0;
		issue       = 1'b0;
		consume     = 1'b0;

		case (state_q)
			FS_IDLE: begin
				if (cmd_acc) begin
					case (action_t'(cmd.action))
						ACT_WRITE: begin
							beat_en = 1'b1;
							if (cmd.last) begin
								load_en     = 1'b1;
								load_status = wr_res.status;
								load_len    = wr_res.length;
							end
							if (wr_res.flush) begin
								state_d = FS_FLUSH;
							end
						end
						ACT_READ: begin
							if (cmd.amount == '0 || !slot_ok(cmd.slot)) begin
								load_en     = 1'b1;
								load_status = ST_INVALID;
							end else if (view.count == '0) begin
								load_en     = 1'b1;
								load_status = ST_EMPTY;
							end else begin
								// fetch the head message length
								rd_latch = 1'b1;
								ln_re    = 1'b1;
								state_d  = FS_RD_LEN;
							end
						end
						ACT_LIMIT: begin
							load_en = 1'b1;
							if (cmd.amount == '0 || cmd.amount > AMT_W'(MAX_MSG_BYTES) ||
							    !slot_ok(cmd.slot)) begin
								load_status = ST_INVALID;
							end else begin
								upd.set_lim = 1'b1;
								upd.lim     = LEN_W'(cmd.amount);
								load_status = ST_OK;
							end
						end
						default: begin
							load_en     = 1'b1;
							load_status = ST_UNKNOWN;
						end
					endcase
				end
			end
			FS_FLUSH: begin
				state_d = FS_IDLE;
			end
			FS_RD_LEN: begin
				if (can_load) begin
					if (AMT_W'(ln_rdata) > rd_amt_q) begin
						// keep the message
						load_en     = 1'b1;
						load_status = ST_SMALL;
						state_d     = FS_IDLE;
					end else begin
						len_latch = 1'b1;
						st_re     = 1'b1;
						state_d   = FS_RD_DATA;
					end
				end
			end
			FS_RD_DATA: begin
				consume = pend_valid_q && can_load;
				issue   = (issue_k_q < nb_q) && (!pend_valid_q || can_load);
				st_re   = issue;
				if (consume) begin
					load_en     = 1'b1;
					load_status = ST_OK;
					load_data   = beat_data;
					load_bc     = beat_bytes;
					load_len    = rd_len_q;
					load_last   = beat_last;
					if (beat_last) begin
						// drop the message from its queue
						upd.pop = 1'b1;
						state_d = FS_IDLE;
					end
				end
			end
			default: begin
				state_d = FS_IDLE;
			end
		endcase
		upd.push = wr_res.push;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= FS_IDLE;
			pend_valid_q <= 1'b0;
			res_valid_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			if (len_latch || issue) begin
				pend_valid_q <= 1'b1;
			end else if (consume) begin
				pend_valid_q <= 1'b0;
			end
			if (load_en) begin
				res_valid_q <= 1'b1;
			end else if (res.ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	// Read context and result payload
	always_ff @(posedge clk) begin
		if (rd_latch) begin
			rd_slot_q <= slot_idx(cmd.slot);
			rd_head_q <= view.head;
			rd_amt_q  <= cmd.amount;
		end
		if (len_latch) begin
			rd_len_q  <= ln_rdata;
			nb_q      <= nb_new;
			issue_k_q <= WCNT_W'(1);
			pend_k_q  <= '0;
		end else if (issue) begin
			issue_k_q <= issue_k_q + WCNT_W'(1);
			pend_k_q  <= WORD_W'(issue_k_q);
		end
		if (load_en) begin
			res_status_q <= load_status;
			res_data_q   <= load_data;
			res_bc_q     <= load_bc;
			res_len_q    <= load_len;
			res_last_q   <= load_last;
		end
	end

	assign res.valid          = res_valid_q;
	assign res.status         = res_status_q;
	assign res.data_res       = res_data_q;
	assign res.byte_count_res = res_bc_q;
	assign res.length         = res_len_q;
	assign res.last_res       = res_last_q;

	// A message ending in a straddling word spends the next cycle writing it
	a_flush: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd_acc && wr_res.flush) |=> (state_q == FS_FLUSH && st_wr.we))
		else $error("straddling word not written after final beat");

	// A pop only ever hits a queue that holds a message
	a_pop: assert property (@(posedge clk) disable iff (!arst_n)
		upd.pop |-> (view.count != '0))
		else $error("pop from an empty queue");

	// A fetched word waits in the store read register while the output stalls
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == FS_RD_DATA && pend_valid_q && !can_load) |=> $stable(st_rdata))
		else $error("pending read word overwritten during a stall");

	// Every data beat of a read carries at least one byte
	a_beat: assert property (@(posedge clk) disable iff (!arst_n)
		(load_en && state_q == FS_RD_DATA) |-> (load_bc != '0))
		else $error("empty read data beat");
endmodule
`default_nettype wire

// File: rtl/mqm_ram.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Simple dual-port RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module mqm_ram #(
	parameter int WIDTH  = 64,
	parameter int ADDR_W = 12
) (
	input  wire logic              clk,
	input  wire logic              we,
	input  wire logic [ADDR_W-1:0] waddr,
	input  wire logic [WIDTH-1:0]  wdata,
	input  wire logic              re,
	input  wire logic [ADDR_W-1:0] raddr,
	output logic      [WIDTH-1:0]  rdata
);
	localparam int DEPTH = 2 ** ADDR_W;

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// Hold the read data while no read is issued
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end
endmodule
`default_nettype wire

// File: rtl/mqm_meta.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Queue bookkeeping
// Head pointer, message count and size limit of every slot, one slot per cycle.
// ----------------------------------------------------------------------------
module mqm_meta import mqm_pkg::*; (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic [SIDX_W-1:0] idx,
	input  wire meta_upd_t         upd,
	output meta_view_t             view
);
	logic [ENTRY_W-1:0] head_q [NUM_SLOTS];
	logic [CNT_W-1:0]   cnt_q  [NUM_SLOTS];
	logic [LEN_W-1:0]   lim_q  [NUM_SLOTS];

	logic [CNT_W:0]     tail_sum;
	logic [ENTRY_W-1:0] head_next;

	always_comb begin
		view.head  = head_q[idx];
		view.count = cnt_q[idx];
		view.limit = lim_q[idx];
		tail_sum   = (CNT_W+1)'(view.head) + (CNT_W+1)'(view.count);
		// wrap: the sum stays below twice the depth
		if (tail_sum >= (CNT_W+1)'(SLOT_DEPTH)) begin
			view.tail = ENTRY_W'(tail_sum - (CNT_W+1)'(SLOT_DEPTH));
		end else begin
			view.tail = ENTRY_W'(tail_sum);
		end
		if (int'(view.head) == SLOT_DEPTH - 1) begin
			head_next = '0;
		end else begin
			head_next = view.head + ENTRY_W'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_SLOTS; i++) begin
				head_q[i] <= '0;
				cnt_q[i]  <= '0;
				lim_q[i]  <= LEN_W'(LIMIT_RESET);
			end
		end else begin
			if (upd.push) begin
				cnt_q[idx] <= view.count + CNT_W'(1);
			end
			if (upd.pop) begin
				head_q[idx] <= head_next;
				cnt_q[idx]  <= view.count - CNT_W'(1);
			end
			if (upd.set_lim) begin
				lim_q[idx] <= upd.lim;
			end
		end
	end
endmodule
`default_nettype wire

// File: rtl/mqm_wpack.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Write beat packer
// Packs write beats into store words, tracks length and error of a message.
// ----------------------------------------------------------------------------
module mqm_wpack import mqm_pkg::*; (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              beat_en,
	input  wire wbeat_t            beat,
	input  wire meta_view_t        view,
	output logic                   busy,
	output logic [SLOT_W-1:0]      slot_q,
	output wres_t                  res,
	output store_wr_t              st_wr,
	output lens_wr_t               ln_wr
);
	logic                wip_q;
	logic [LEN_W-1:0]    wlen_q;
	status_t             werr_q;
	logic [DATA_W-1:0]   acc_q;
	logic                flush_q;
	logic [STORE_AW-1:0] flush_addr_q;

	logic                start;
	logic [SLOT_W-1:0]   s;
	logic [SIDX_W-1:0]   sidx;
	status_t             err0;
	status_t             err1;
	logic [LEN_W-1:0]    len0;
	logic [LEN_W-1:0]    len1;
	logic [BC_W-1:0]     bc;
	logic [LEN_W:0]      sum;
	logic [2:0]          ofs;
	logic [2*DATA_W-1:0] wide;
	logic [DATA_W-1:0]   low_word;
	logic                spill;
	logic [WORD_W-1:0]   word0;
	logic                ok;

	always_comb begin
		start = !wip_q;
		s     = start ? beat.slot : slot_q;
		sidx  = slot_idx(s);
		if (!start) begin
			err0 = werr_q;
		end else if (!slot_ok(s)) begin
			err0 = ST_INVALID;
		end else if (view.count >= CNT_W'(SLOT_DEPTH)) begin
			err0 = ST_FULL;
		end else begin
			err0 = ST_OK;
		end
		len0 = start ? '0 : wlen_q;
		bc   = (beat.byte_count > BC_W'(BEAT_BYTES)) ? BC_W'(BEAT_BYTES) : beat.byte_count;
		sum  = {1'b0, len0} + (LEN_W+1)'(bc);
		// a byte that lands at or past the limit marks the message too big
		if (err0 == ST_OK && bc != '0 && sum > {1'b0, view.limit}) begin
			err1 = ST_BIG;
		end else begin
			err1 = err0;
		end
		len1 = sum[LEN_W] ? '1 : sum[LEN_W-1:0];

		// place the beat at the running byte offset
		ofs  = len0[2:0];
		wide = {{DATA_W{1'b0}}, beat.data} << {ofs, 3'b000};
		for (int j = 0; j < BEAT_BYTES; j++) begin
			low_word[8*j +: 8] = (j < int'(ofs)) ? acc_q[8*j +: 8] : wide[8*j +: 8];
		end
		spill = ({1'b0, ofs} + bc) > BC_W'(BEAT_BYTES);
		word0 = WORD_W'(len0 >> 3);

		if (len1 == '0) begin
			res.status = ST_INVALID;
		end else if (err1 != ST_OK) begin
			res.status = err1;
		end else if (len1 > view.limit) begin
			res.status = ST_BIG;
		end else if (view.count >= CNT_W'(SLOT_DEPTH)) begin
			res.status = ST_FULL;
		end else begin
			res.status = ST_OK;
		end
		ok         = (res.status == ST_OK);
		res.length = ok ? len1 : '0;
		res.push   = beat_en && beat.last && ok;
		res.flush  = res.push && spill;

		// the straddling word of a finished message goes out in the next cycle
		if (flush_q) begin
			st_wr.we   = 1'b1;
			st_wr.addr = flush_addr_q;
			st_wr.data = acc_q;
		end else begin
			st_wr.we   = beat_en && bc != '0 && err1 == ST_OK;
			st_wr.addr = store_addr(sidx, view.tail, word0);
			st_wr.data = low_word;
		end

		ln_wr.we   = res.push;
		ln_wr.addr = lens_addr(sidx, view.tail);
		ln_wr.data = len1;

		busy = wip_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wip_q   <= 1'b0;
			slot_q  <= '0;
			wlen_q  <= '0;
			werr_q  <= ST_OK;
			flush_q <= 1'b0;
		end else begin
			flush_q <= res.flush;
			if (beat_en) begin
				wip_q  <= !beat.last;
				slot_q <= s;
				wlen_q <= len1;
				werr_q <= err1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (beat_en) begin
			acc_q        <= spill ? wide[2*DATA_W-1:DATA_W] : low_word;
			flush_addr_q <= store_addr(sidx, view.tail, word0 + WORD_W'(1));
		end
	end
endmodule
`default_nettype wire
